[rtl/kpc_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// kpc_pkg
// Shared types and constants for the key press classifier: field widths,
// configuration register indexes, reset values and lane structs.
// ============================================================================
package kpc_pkg;

    // field widths
    localparam int KEY_W  = 7;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_SHORT_MIN  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_LONG_PRESS = 3'd1;
    localparam logic [IDX_W-1:0] CFG_REP_SLOW   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_REP_FAST   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_ACCEL      = 3'd4;
    localparam logic [IDX_W-1:0] CFG_REP_ENABLE = 3'd5;

    // register reset values
    localparam logic [CFG_W-1:0] RST_SHORT_MIN  = 16'd25;
    localparam logic [CFG_W-1:0] RST_LONG_PRESS = 16'd800;
    localparam logic [CFG_W-1:0] RST_REP_SLOW   = 16'd150;
    localparam logic [CFG_W-1:0] RST_REP_FAST   = 16'd50;
    localparam logic [CFG_W-1:0] RST_ACCEL      = 16'd2000;
    localparam logic [KEY_W-1:0] RST_REP_ENABLE = 7'd0;

    // input kind codes
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_SYNC   = 1'b1;

    // timing registers shared by all lanes
    typedef struct packed {
        logic [CFG_W-1:0] short_min;
        logic [CFG_W-1:0] long_press;
        logic [CFG_W-1:0] rep_slow;
        logic [CFG_W-1:0] rep_fast;
        logic [CFG_W-1:0] accel;
    } t_cfg;

    // events found by one lane for one request
    typedef struct packed {
        logic short_ev;
        logic long_ev;
        logic rep_ev;
        logic press_ev;
    } t_lane_ev;

endpackage

[rtl/kpc_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// kpc_if
// Valid/ready channels of the key press classifier: key samples in,
// event masks out.
// ============================================================================
interface kpc_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [kpc_pkg::TIME_W-1:0]    now_ms;
    logic [kpc_pkg::KEY_W-1:0]     key_levels;

    modport source (output valid, kind, now_ms, key_levels, input ready);
    modport sink   (input valid, kind, now_ms, key_levels, output ready);
endinterface

interface kpc_out_if;
    logic                          valid;
    logic                          ready;
    logic [kpc_pkg::KEY_W-1:0]     short_mask;
    logic [kpc_pkg::KEY_W-1:0]     long_mask;
    logic [kpc_pkg::KEY_W-1:0]     repeat_mask;
    logic [kpc_pkg::KEY_W-1:0]     press_mask;

    modport source (output valid, short_mask, long_mask, repeat_mask, press_mask,
                    input ready);
    modport sink   (input valid, short_mask, long_mask, repeat_mask, press_mask,
                    output ready);
endinterface

[rtl/key_press_classifier.sv]
`timescale 1ns / 1ps
// ============================================================================
// key_press_classifier
// Short, long, press and auto-repeat classifier for a row of active-low keys.
// ============================================================================
//  channel   dir  payload                                        handshake
//  i_key     in   kind, now_ms, key_levels                       valid/ready
//  o_evt     out  short_mask, long_mask, repeat_mask, press_mask valid/ready
//  i_cfg_*   in   idx (3b), wdata (16b)                          we only
//
//  One request per cycle while i_key ready is high; its result is registered.
//  Each key lane finishes its compares in the accept cycle, so the lane state
//  is current for the next request. Reset is synchronous and restores the
//  register defaults and released lanes. A stalled result sits in the output
//  register; one more request fits in the skid register, after which i_key
//  ready drops until the output side drains.
// ============================================================================
module key_press_classifier #(
    parameter int NUM_KEYS = 7
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    kpc_in_if.sink                            i_key,
    kpc_out_if.source                         o_evt,
    input  logic                              i_cfg_we,
    input  logic [kpc_pkg::IDX_W-1:0]         i_cfg_idx,
    input  logic [kpc_pkg::CFG_W-1:0]         i_cfg_wdata
);

    localparam int KW = kpc_pkg::KEY_W;

    kpc_pkg::t_cfg                      r_cfg;
    logic [KW-1:0]                      r_rep_en;
    kpc_pkg::t_lane_ev [NUM_KEYS-1:0]   lane_ev;
    logic                               accept;
    logic                               merge_ready;

    assign i_key.ready = merge_ready;
    assign accept      = i_key.valid && merge_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_min  <= kpc_pkg::RST_SHORT_MIN;
            r_cfg.long_press <= kpc_pkg::RST_LONG_PRESS;
            r_cfg.rep_slow   <= kpc_pkg::RST_REP_SLOW;
            r_cfg.rep_fast   <= kpc_pkg::RST_REP_FAST;
            r_cfg.accel      <= kpc_pkg::RST_ACCEL;
            r_rep_en         <= kpc_pkg::RST_REP_ENABLE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kpc_pkg::CFG_SHORT_MIN:  r_cfg.short_min  <= i_cfg_wdata;
                kpc_pkg::CFG_LONG_PRESS: r_cfg.long_press <= i_cfg_wdata;
                kpc_pkg::CFG_REP_SLOW:   r_cfg.rep_slow   <= i_cfg_wdata;
                kpc_pkg::CFG_REP_FAST:   r_cfg.rep_fast   <= i_cfg_wdata;
                kpc_pkg::CFG_ACCEL:      r_cfg.accel      <= i_cfg_wdata;
                kpc_pkg::CFG_REP_ENABLE: r_rep_en         <= i_cfg_wdata[KW-1:0];
                default: ;
            endcase
        end
    end

    // key lanes; lanes past the level field see a held key
    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
        logic lvl;
        logic en;
        if (g < KW) begin : g_in
            assign lvl = i_key.key_levels[g];
            assign en  = r_rep_en[g];
        end else begin : g_out
            assign lvl = 1'b0;
            assign en  = 1'b0;
        end

        kpc_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_accept (accept),
            .i_kind   (i_key.kind),
            .i_now_ms (i_key.now_ms),
            .i_level  (lvl),
            .i_enable (en),
            .i_cfg    (r_cfg),
            .o_ev     (lane_ev[g])
        );
    end

    // merge lane events and buffer the result
    kpc_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_ev     (lane_ev),
        .o_ready  (merge_ready),
        .o_evt    (o_evt)
    );

endmodule

[rtl/kpc_lane.sv]
`timescale 1ns / 1ps
// ============================================================================
// kpc_lane
// One key lane: holds the level, press start, long flag and last repeat
// time of a key and classifies each accepted request in the same cycle.
// ============================================================================
module kpc_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_kind,
    input  logic [kpc_pkg::TIME_W-1:0]  i_now_ms,
    input  logic                        i_level,
    input  logic                        i_enable,
    input  kpc_pkg::t_cfg               i_cfg,
    output kpc_pkg::t_lane_ev           o_ev
);

    logic                        r_level, n_level;
    logic                        r_long_done, n_long_done;
    logic [kpc_pkg::TIME_W-1:0]  r_press_ms, n_press_ms;
    logic [kpc_pkg::TIME_W-1:0]  r_rep_ms, n_rep_ms;

    logic                        press_edge;
    logic                        release_edge;
    logic                        long_flag;
    logic [kpc_pkg::TIME_W-1:0]  hold_old;
    logic [kpc_pkg::TIME_W-1:0]  hold;
    logic [kpc_pkg::TIME_W-1:0]  since_rep;
    logic [kpc_pkg::TIME_W-1:0]  interval;
    logic                        long_fire;
    logic                        rep_fire;

    // elapsed times, modulo 2^32; a fresh press counts from zero
    assign press_edge   = (i_level != r_level) && !i_level;
    assign release_edge = (i_level != r_level) && i_level;
    assign hold_old     = i_now_ms - r_press_ms;
    assign hold         = press_edge ? '0 : hold_old;
    assign since_rep    = press_edge ? '0 : (i_now_ms - r_rep_ms);
    assign long_flag    = press_edge ? 1'b0 : r_long_done;

    // long and repeat decisions on the updated level
    assign long_fire = !i_level && !long_flag &&
                       (hold >= {16'd0, i_cfg.long_press});
    assign interval  = (hold > {16'd0, i_cfg.accel}) ? {16'd0, i_cfg.rep_fast}
                                                     : {16'd0, i_cfg.rep_slow};
    assign rep_fire  = i_enable && !i_level && (since_rep >= interval);

    // events are zero on a sync request
    always_comb begin
        o_ev.short_ev = (i_kind == kpc_pkg::KIND_SAMPLE) && release_edge &&
                        !r_long_done && (hold_old > {16'd0, i_cfg.short_min});
        o_ev.long_ev  = (i_kind == kpc_pkg::KIND_SAMPLE) && long_fire;
        o_ev.rep_ev   = (i_kind == kpc_pkg::KIND_SAMPLE) && rep_fire;
        o_ev.press_ev = (i_kind == kpc_pkg::KIND_SAMPLE) && press_edge && i_enable;
    end

    // next lane state
    always_comb begin
        n_level     = r_level;
        n_long_done = r_long_done;
        n_press_ms  = r_press_ms;
        n_rep_ms    = r_rep_ms;
        if (i_accept) begin
            n_level = i_level;
            if (i_kind == kpc_pkg::KIND_SYNC) begin
                // absorb held keys without events
                n_press_ms  = i_now_ms;
                n_rep_ms    = i_now_ms;
                n_long_done = !i_level;
            end else begin
                if (press_edge) begin
                    n_press_ms = i_now_ms;
                    n_rep_ms   = i_now_ms;
                end
                n_long_done = long_flag || long_fire;
                if (rep_fire) begin
                    n_rep_ms = i_now_ms;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= 1'b1;
            r_long_done <= 1'b0;
            r_press_ms  <= '0;
            r_rep_ms    <= '0;
        end else begin
            r_level     <= n_level;
            r_long_done <= n_long_done;
            r_press_ms  <= n_press_ms;
            r_rep_ms    <= n_rep_ms;
        end
    end

endmodule

[rtl/kpc_merge.sv]
`timescale 1ns / 1ps
// ============================================================================
// kpc_merge
// Gathers the lane events into the four result masks and holds them in an
// output register backed by a skid register.
// ============================================================================
module kpc_merge #(
    parameter int NUM_KEYS = 7
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_accept,
    input  kpc_pkg::t_lane_ev [NUM_KEYS-1:0]      i_ev,
    output logic                                  o_ready,
    kpc_out_if.source                             o_evt
);

    localparam int KW = kpc_pkg::KEY_W;

    typedef struct packed {
        logic [KW-1:0] short_mask;
        logic [KW-1:0] long_mask;
        logic [KW-1:0] repeat_mask;
        logic [KW-1:0] press_mask;
    } t_result;

    t_result  res;
    t_result  r_out, n_out;
    t_result  r_skid, n_skid;
    logic     r_out_valid, n_out_valid;
    logic     r_skid_valid, n_skid_valid;
    logic     out_fire;

    // lanes beyond the field width are dropped
    always_comb begin
        res = '0;
        for (int b = 0; b < KW; b++) begin
            if (b < NUM_KEYS) begin
                res.short_mask[b]  = i_ev[b].short_ev;
                res.long_mask[b]   = i_ev[b].long_ev;
                res.repeat_mask[b] = i_ev[b].rep_ev;
                res.press_mask[b]  = i_ev[b].press_ev;
            end
        end
    end

    assign out_fire = r_out_valid && o_evt.ready;
    assign o_ready  = !r_skid_valid;

    // output register with skid stage
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (i_accept) begin
            if (!r_out_valid || out_fire) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = res;
                n_skid_valid = 1'b1;
            end
        end else if (out_fire) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_evt.valid       = r_out_valid;
    assign o_evt.short_mask  = r_out.short_mask;
    assign o_evt.long_mask   = r_out.long_mask;
    assign o_evt.repeat_mask = r_out.repeat_mask;
    assign o_evt.press_mask  = r_out.press_mask;

endmodule

[rtl/kpc_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// kpc_checker
// Port-level checks of the key press classifier, bound to the top level.
// ============================================================================
module kpc_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_ready,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [kpc_pkg::KEY_W-1:0]   i_short_mask,
    input  logic [kpc_pkg::KEY_W-1:0]   i_long_mask,
    input  logic [kpc_pkg::KEY_W-1:0]   i_press_mask
);

    // a stalled result keeps its short and long masks
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_short_mask) && $stable(i_long_mask)))
        else $error("stalled result changed");

    // a release never reports long or press for the same key
    a_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (((i_short_mask & i_long_mask) == '0) &&
                         ((i_short_mask & i_press_mask) == '0)))
        else $error("short event overlaps long or press event");

    // with nothing buffered the input side is open
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind key_press_classifier kpc_checker u_kpc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_key.ready),
    .i_out_valid  (o_evt.valid),
    .i_out_ready  (o_evt.ready),
    .i_short_mask (o_evt.short_mask),
    .i_long_mask  (o_evt.long_mask),
    .i_press_mask (o_evt.press_mask)
);

[test/key_press_classifier_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// key_press_classifier_test
// Self-checking bench for the key press classifier. Sends key samples and sync
// requests over the valid/ready input channel, predicts the event masks of
// every request in a cycle-free model of the key lanes, and compares each
// result from the output channel field by field. Directed cases come first,
// then random press/hold/release traffic under several timing settings.
// ============================================================================
module key_press_classifier_test;

    localparam int KW = kpc_pkg::KEY_W;
    localparam int TW = kpc_pkg::TIME_W;
    localparam int CW = kpc_pkg::CFG_W;
    localparam int IW = kpc_pkg::IDX_W;

    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        logic [KW-1:0] short_m;
        logic [KW-1:0] long_m;
        logic [KW-1:0] rep_m;
        logic [KW-1:0] press_m;
    } t_evt_masks;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [IW-1:0] i_cfg_idx;
    logic [CW-1:0] i_cfg_wdata;

    kpc_in_if  key_if ();
    kpc_out_if evt_if ();

    key_press_classifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (key_if),
        .o_evt       (evt_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // timing registers as the lanes see them
    logic [CW-1:0] cfg_short_min, cfg_long_press, cfg_rep_slow, cfg_rep_fast, cfg_accel;
    logic [KW-1:0] cfg_rep_enable;

    // per-lane state
    logic [KW-1:0] lane_level;
    logic [KW-1:0] lane_long_done;
    logic [TW-1:0] lane_start [KW];
    logic [TW-1:0] lane_last_rep [KW];

    t_evt_masks events_due_q [$];
    t_evt_masks want_ev;

    bit mismatch_seen;
    bit steady_flow;
    int ready_hold;
    int idle_cycles;

    logic [TW-1:0] clock_ms;
    logic [KW-1:0] cur_levels;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // lane model
    // ------------------------------------------------------------------------
    task automatic reset_lanes();
        cfg_short_min  = kpc_pkg::RST_SHORT_MIN;
        cfg_long_press = kpc_pkg::RST_LONG_PRESS;
        cfg_rep_slow   = kpc_pkg::RST_REP_SLOW;
        cfg_rep_fast   = kpc_pkg::RST_REP_FAST;
        cfg_accel      = kpc_pkg::RST_ACCEL;
        cfg_rep_enable = kpc_pkg::RST_REP_ENABLE;
        lane_level     = '1;
        lane_long_done = '0;
        for (int k = 0; k < KW; k++) begin
            lane_start[k]    = '0;
            lane_last_rep[k] = '0;
        end
    endtask

    function automatic t_evt_masks classify_keys(input logic kind,
                                                 input logic [TW-1:0] now,
                                                 input logic [KW-1:0] levels);
        t_evt_masks ev;
        logic [TW-1:0] hold;
        logic [TW-1:0] since_rep;
        logic [TW-1:0] interval;
        ev = '0;
        for (int k = 0; k < KW; k++) begin
            if (kind == kpc_pkg::KIND_SYNC) begin
                // take the level as is, held keys count as already reported
                lane_level[k]     = levels[k];
                lane_start[k]     = now;
                lane_last_rep[k]  = now;
                lane_long_done[k] = ~levels[k];
            end else begin
                if (levels[k] != lane_level[k]) begin
                    lane_level[k] = levels[k];
                    if (levels[k] == 1'b0) begin
                        lane_start[k]     = now;
                        lane_long_done[k] = 1'b0;
                        lane_last_rep[k]  = now;
                        ev.press_m[k]     = cfg_rep_enable[k];
                    end else begin
                        hold = now - lane_start[k];
                        if (!lane_long_done[k] && hold > TW'(cfg_short_min))
                            ev.short_m[k] = 1'b1;
                    end
                end
                hold = now - lane_start[k];
                if (lane_level[k] == 1'b0 && !lane_long_done[k] &&
                    hold >= TW'(cfg_long_press)) begin
                    lane_long_done[k] = 1'b1;
                    ev.long_m[k]      = 1'b1;
                end
                if (cfg_rep_enable[k] && lane_level[k] == 1'b0) begin
                    interval  = (hold > TW'(cfg_accel)) ? TW'(cfg_rep_fast)
                                                        : TW'(cfg_rep_slow);
                    since_rep = now - lane_last_rep[k];
                    if (since_rep >= interval) begin
                        lane_last_rep[k] = now;
                        ev.rep_m[k]      = 1'b1;
                    end
                end
            end
        end
        return ev;
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    task automatic send_key(input logic kind, input logic [TW-1:0] now,
                            input logic [KW-1:0] levels);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        @(negedge i_clk);
        if (gap > 0) begin
            key_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        key_if.kind       = kind;
        key_if.now_ms     = now;
        key_if.key_levels = levels;
        key_if.valid      = 1'b1;
        do @(posedge i_clk); while (!key_if.ready);
        events_due_q.push_back(classify_keys(kind, now, levels));
    endtask

    // drop valid and wait until every result is back
    task automatic settle_idle();
        @(negedge i_clk);
        key_if.valid = 1'b0;
        while (events_due_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IW-1:0] idx, input logic [CW-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = data;
        @(posedge i_clk);
        case (idx)
            kpc_pkg::CFG_SHORT_MIN:  cfg_short_min  = data;
            kpc_pkg::CFG_LONG_PRESS: cfg_long_press = data;
            kpc_pkg::CFG_REP_SLOW:   cfg_rep_slow   = data;
            kpc_pkg::CFG_REP_FAST:   cfg_rep_fast   = data;
            kpc_pkg::CFG_ACCEL:      cfg_accel      = data;
            kpc_pkg::CFG_REP_ENABLE: cfg_rep_enable = data[KW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_timing(input logic [CW-1:0] short_min, input logic [CW-1:0] long_p,
                              input logic [CW-1:0] slow, input logic [CW-1:0] fast,
                              input logic [CW-1:0] accel, input logic [KW-1:0] rep_en);
        settle_idle();
        write_reg(kpc_pkg::CFG_SHORT_MIN, short_min);
        write_reg(kpc_pkg::CFG_LONG_PRESS, long_p);
        write_reg(kpc_pkg::CFG_REP_SLOW, slow);
        write_reg(kpc_pkg::CFG_REP_FAST, fast);
        write_reg(kpc_pkg::CFG_ACCEL, accel);
        write_reg(kpc_pkg::CFG_REP_ENABLE, CW'(rep_en));
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // random press/hold/release traffic; mostly small time steps with some
    // syncs, backward time jumps and fully random requests mixed in
    task automatic run_key_traffic(input int count, input int step_max);
        int pick;
        logic kind;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            kind = kpc_pkg::KIND_SAMPLE;
            if (pick < 4) begin
                kind       = ($urandom_range(0, 1) == 1) ? kpc_pkg::KIND_SYNC
                                                          : kpc_pkg::KIND_SAMPLE;
                clock_ms   = $urandom();
                cur_levels = KW'($urandom_range(0, 127));
            end else if (pick < 9) begin
                kind     = kpc_pkg::KIND_SYNC;
                clock_ms = clock_ms + $urandom_range(0, step_max);
            end else if (pick < 12) begin
                clock_ms = clock_ms - $urandom_range(1, 1000);
            end else begin
                clock_ms = clock_ms + $urandom_range(0, step_max);
                for (int k = 0; k < KW; k++)
                    if ($urandom_range(0, 5) == 0) cur_levels[k] = ~cur_levels[k];
            end
            send_key(kind, clock_ms, cur_levels);
        end
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls, compare against oldest prediction
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            evt_if.ready = 1'b0;
            ready_hold--;
        end else begin
            evt_if.ready = 1'b1;
        end
    end

    function automatic void check_field(input string name, input logic [KW-1:0] want,
                                        input logic [KW-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_seen = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && evt_if.valid && evt_if.ready) begin
            ready_hold = steady_flow ? 0 : $urandom_range(0, 5);
            if (events_due_q.size() == 0) begin
                $display("%0t: result with no request pending, expected none, actual %h %h %h %h",
                         $time, evt_if.short_mask, evt_if.long_mask,
                         evt_if.repeat_mask, evt_if.press_mask);
                mismatch_seen = 1'b1;
            end else begin
                want_ev = events_due_q.pop_front();
                check_field("short_mask", want_ev.short_m, evt_if.short_mask);
                check_field("long_mask", want_ev.long_m, evt_if.long_mask);
                check_field("repeat_mask", want_ev.rep_m, evt_if.repeat_mask);
                check_field("press_mask", want_ev.press_m, evt_if.press_mask);
            end
        end
    end

    // watchdog: too long without any handshake or register write
    always @(posedge i_clk) begin
        if (!i_rst_n || (key_if.valid && key_if.ready) || (evt_if.valid && evt_if.ready) ||
            i_cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: watchdog, no handshake for %0d cycles", $time, idle_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_short_and_long();
        send_key(kpc_pkg::KIND_SAMPLE, 32'd1000, 7'h7E);    // press key 0
        send_key(kpc_pkg::KIND_SAMPLE, 32'd1030, 7'h7F);    // short, hold above minimum
        send_key(kpc_pkg::KIND_SAMPLE, 32'd2000, 7'h7D);
        send_key(kpc_pkg::KIND_SAMPLE, 32'd2025, 7'h7F);    // hold equals minimum: no short
        send_key(kpc_pkg::KIND_SAMPLE, 32'd3000, 7'h00);    // all keys down
        send_key(kpc_pkg::KIND_SAMPLE, 32'd3800, 7'h00);    // long fires
        send_key(kpc_pkg::KIND_SAMPLE, 32'd3900, 7'h7F);    // release after long: no short
    endtask

    task automatic test_press_repeat();
        set_timing(kpc_pkg::RST_SHORT_MIN, kpc_pkg::RST_LONG_PRESS, kpc_pkg::RST_REP_SLOW,
                   kpc_pkg::RST_REP_FAST, kpc_pkg::RST_ACCEL, 7'h7F);
        send_key(kpc_pkg::KIND_SAMPLE, 32'd5000, 7'h2A);    // press notification
        send_key(kpc_pkg::KIND_SAMPLE, 32'd5150, 7'h2A);    // slow repeat
        send_key(kpc_pkg::KIND_SAMPLE, 32'd7001, 7'h2A);    // past accel: long and fast repeat
        send_key(kpc_pkg::KIND_SAMPLE, 32'd7051, 7'h00);
    endtask

    task automatic test_sync_absorb();
        send_key(kpc_pkg::KIND_SYNC,   32'd8000, 7'h70);
        send_key(kpc_pkg::KIND_SAMPLE, 32'd9000, 7'h70);    // absorbed keys: no long
        send_key(kpc_pkg::KIND_SAMPLE, 32'd9100, 7'h7F);    // and no short on release
    endtask

    task automatic test_zero_long();
        set_timing(kpc_pkg::RST_SHORT_MIN, 16'd0, kpc_pkg::RST_REP_SLOW,
                   kpc_pkg::RST_REP_FAST, kpc_pkg::RST_ACCEL, 7'h00);
        send_key(kpc_pkg::KIND_SAMPLE, 32'd10000, 7'h3F);   // long on the press itself
        send_key(kpc_pkg::KIND_SAMPLE, 32'd10010, 7'h7F);
    endtask

    task automatic test_zero_repeat();
        set_timing(kpc_pkg::RST_SHORT_MIN, kpc_pkg::RST_LONG_PRESS, 16'd0, 16'd0,
                   kpc_pkg::RST_ACCEL, 7'h01);
        send_key(kpc_pkg::KIND_SAMPLE, 32'd11000, 7'h7E);
        send_key(kpc_pkg::KIND_SAMPLE, 32'd11000, 7'h7E);   // repeats with no time passed
        send_key(kpc_pkg::KIND_SAMPLE, 32'd11001, 7'h7F);
    endtask

    task automatic test_wrapped_time();
        set_timing(kpc_pkg::RST_SHORT_MIN, kpc_pkg::RST_LONG_PRESS, kpc_pkg::RST_REP_SLOW,
                   kpc_pkg::RST_REP_FAST, kpc_pkg::RST_ACCEL, 7'h7F);
        send_key(kpc_pkg::KIND_SAMPLE, 32'hFFFF_FFF0, 7'h7E);
        send_key(kpc_pkg::KIND_SAMPLE, 32'h0000_0010, 7'h7F);  // hold across the wrap
        send_key(kpc_pkg::KIND_SAMPLE, 32'hFFFF_FFFF, 7'h7E);
        send_key(kpc_pkg::KIND_SAMPLE, 32'h0000_0000, 7'h7E);
        send_key(kpc_pkg::KIND_SAMPLE, 32'h0000_0100, 7'h7E);
        send_key(kpc_pkg::KIND_SAMPLE, 32'h0000_0050, 7'h7F);  // time went back: hold still counts from the press
    endtask

    task automatic test_random_traffic();
        clock_ms   = $urandom();
        cur_levels = '1;
        set_timing(kpc_pkg::RST_SHORT_MIN, kpc_pkg::RST_LONG_PRESS, kpc_pkg::RST_REP_SLOW,
                   kpc_pkg::RST_REP_FAST, kpc_pkg::RST_ACCEL, 7'h7F);
        run_key_traffic(80, 200);
        // back-to-back stretch with tight thresholds
        set_timing(16'd10, 16'd60, 16'd15, 16'd4, 16'd100, KW'($urandom_range(0, 127)));
        steady_flow = 1'b1;
        run_key_traffic(60, 20);
        settle_idle();
        steady_flow = 1'b0;
        repeat (3) begin
            set_timing(CW'($urandom_range(0, 40)), CW'($urandom_range(0, 300)),
                       CW'($urandom_range(1, 60)), CW'($urandom_range(1, 20)),
                       CW'($urandom_range(0, 400)), KW'($urandom_range(0, 127)));
            run_key_traffic(60, 40);
        end
    endtask

    task automatic test_config_extremes();
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'h7F);
        run_key_traffic(40, 30000);
        set_timing(16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 7'h7F);
        run_key_traffic(40, 5);
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = kpc_pkg::CFG_SHORT_MIN;
        i_cfg_wdata       = '0;
        key_if.valid      = 1'b0;
        key_if.kind       = kpc_pkg::KIND_SAMPLE;
        key_if.now_ms     = '0;
        key_if.key_levels = '1;
        evt_if.ready      = 1'b0;
        ready_hold        = 0;
        idle_cycles       = 0;
        mismatch_seen     = 1'b0;
        steady_flow       = 1'b0;
        reset_lanes();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_short_and_long();
        test_press_repeat();
        test_sync_absorb();
        test_zero_long();
        test_zero_repeat();
        test_wrapped_time();
        test_random_traffic();
        test_config_extremes();

        settle_idle();
        if (!mismatch_seen)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[filelist.f]
rtl/kpc_pkg.sv
rtl/kpc_if.sv
rtl/kpc_lane.sv
rtl/kpc_merge.sv
rtl/key_press_classifier.sv
rtl/kpc_checker.sv
test/key_press_classifier_test.sv
